// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the voltage clamp controller.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PVC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is held.
`define PVC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

// File: rtl/pvc_pkg.sv
// Package of the voltage clamp controller: constants, codes, FSM and control types.
// Depends on nothing; used by pvc_mac_unit and pid_voltage_clamp_core.
package pvc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DECAY_BITS    = 16;
  localparam logic [16:0] DECAY_ONE = 17'h10000;

  // Accumulator holds a 64 x 32 bit product magnitude plus sign and rounding headroom.
  localparam int ACC_W  = 97;
  // Shift amounts stay below 32 (fraction bits at most 30, plus one).
  localparam int SH_W   = 5;
  // Product terms saturate to +-2^60, so 62 bits signed carry them.
  localparam int TERM_W = 62;
  localparam logic [60:0] TERM_LIMIT = 61'h1000_0000_0000_0000;

  typedef enum logic [2:0] {
    REG_DECAY  = 3'd0,
    REG_STEADY = 3'd1,
    REG_INIT   = 3'd2,
    REG_GAIN   = 3'd3,
    REG_DCOEF  = 3'd4,
    REG_ICOEF  = 3'd5,
    REG_SAT    = 3'd6
  } pvc_reg_t;

  typedef enum logic [1:0] {
    OP_MIX,
    OP_DER,
    OP_INT,
    OP_GAIN
  } pvc_op_t;

  localparam logic [1:0] CLAMP_NONE = 2'd0;
  localparam logic [1:0] CLAMP_HIGH = 2'd1;
  localparam logic [1:0] CLAMP_LOW  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX0,
    ST_MIX1,
    ST_MIX2,
    ST_NORM,
    ST_SHIFT,
    ST_ERR,
    ST_INTG,
    ST_LO,
    ST_HI,
    ST_HIADD,
    ST_GLOAD,
    ST_CLAMP
  } pvc_state_t;

  typedef struct packed {
    logic            clr;
    logic            acc_en;
    logic            acc_hi;
    logic            acc_neg;
    logic            norm_en;
    logic [SH_W-1:0] sh;
  } pvc_mac_ctl_t;

endpackage

// File: rtl/pid_voltage_clamp_core.sv
// One sample at a time: in_tready stays low from the accepted input beat until its result
// is loaded into the output register. The steps follow from the single shared 32x32
// multiplier: the command mix takes two products, and each of the derivative, integral and
// gain terms takes a low and a high pass followed by accumulate, round and saturate steps.
// Reset: synchronous, active-low rst_n restores register defaults and clears command,
// last error, integral and the output valid flag.
`include "assert_macros.svh"

module pid_voltage_clamp_core #(
  parameter int FRAC_BITS = pvc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input beat
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] measured_voltage
  // result beat
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] drive_current
  output logic [1:0]  out_tuser,  // [1:0] clamp_state
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata
);

  // Rescaling shifts: the decay mix uses the decay fraction, the other terms FRAC_BITS,
  // and the integral term one bit more to apply the trapezoid's one half exactly.
  localparam logic [pvc_pkg::SH_W-1:0] SH_DECAY = pvc_pkg::SH_W'(pvc_pkg::DECAY_BITS);
  localparam logic [pvc_pkg::SH_W-1:0] SH_FRAC  = pvc_pkg::SH_W'(FRAC_BITS);
  localparam logic [pvc_pkg::SH_W-1:0] SH_INT   = pvc_pkg::SH_W'(FRAC_BITS + 1);

  // Configuration registers
  logic [16:0]        decay_r, decay_nxt;
  logic signed [31:0] steady_r, steady_nxt;
  logic [31:0]        gain_r, gain_nxt;
  logic [31:0]        dcoef_r, dcoef_nxt;
  logic [31:0]        icoef_r, icoef_nxt;
  logic [30:0]        sat_r, sat_nxt;

  // Loop state
  logic signed [31:0] cmd_r, cmd_nxt;
  logic signed [31:0] last_err_r, last_err_nxt;
  logic signed [47:0] integ_r, integ_nxt;

  // Working registers of one sample
  pvc_pkg::pvc_state_t state_r, state_nxt;
  pvc_pkg::pvc_op_t    op_r, op_nxt;
  logic signed [31:0]  v_r, v_nxt;
  logic signed [31:0]  e_r, e_nxt;
  logic signed [47:0]  new_int_r, new_int_nxt;
  logic [63:0]         opm_r, opm_nxt;
  logic                tneg_r, tneg_nxt;
  logic signed [63:0]  sum_r, sum_nxt;
  logic signed [61:0]  drv_r, drv_nxt;

  // Output stage
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_drive_r, out_drive_nxt;
  logic [1:0]  out_clamp_r, out_clamp_nxt;

  // Shared unit hookup
  pvc_pkg::pvc_mac_ctl_t     ctl;
  logic [31:0]               mul_a;
  logic [31:0]               mul_b;
  logic [pvc_pkg::ACC_W-1:0] q;
  logic                      acc_sign;

  // Combinational helpers
  logic [16:0]        d_eff;
  logic [16:0]        d_comp;
  logic [31:0]        cmd_mag;
  logic [31:0]        steady_mag;
  logic [31:0]        coef;
  logic [60:0]        q_sat;
  logic [61:0]        term_mag;
  logic signed [61:0] term;
  logic [31:0]        cmd_new;
  logic [32:0]        err_diff;
  logic [31:0]        err_sat;
  logic [49:0]        int_sum;
  logic [47:0]        int_sat;
  logic [32:0]        de_diff;
  logic [32:0]        de_mag;
  logic [47:0]        ni_mag;
  logic [63:0]        sum_mag;
  logic signed [61:0] sat_pos;
  logic signed [61:0] sat_neg;
  logic               load_out;

  pvc_mac_unit u_mac (
    .clk      (clk),
    .ctl      (ctl),
    .mul_a    (mul_a),
    .mul_b    (mul_b),
    .q        (q),
    .acc_sign (acc_sign)
  );

  // Operand preparation: decay above one acts as one; magnitudes feed the unsigned multiplier.
  always_comb begin
    d_eff      = (decay_r > pvc_pkg::DECAY_ONE) ? pvc_pkg::DECAY_ONE : decay_r;
    d_comp     = pvc_pkg::DECAY_ONE - d_eff;
    cmd_mag    = cmd_r[31] ? (~cmd_r + 32'd1) : cmd_r;
    steady_mag = steady_r[31] ? (~steady_r + 32'd1) : steady_r;

    case (op_r)
      pvc_pkg::OP_DER:  coef = dcoef_r;
      pvc_pkg::OP_INT:  coef = icoef_r;
      pvc_pkg::OP_GAIN: coef = gain_r;
      default:          coef = 32'(d_eff);
    endcase

    // Term result: saturate the rounded magnitude to 2^60, then restore the sign.
    q_sat    = (q > pvc_pkg::ACC_W'(pvc_pkg::TERM_LIMIT)) ? pvc_pkg::TERM_LIMIT : q[60:0];
    term_mag = {1'b0, q_sat};
    term     = tneg_r ? $signed(~term_mag + 62'd1) : $signed(term_mag);

    // Command mix result saturates to 32 bits signed.
    if (!tneg_r) begin
      cmd_new = (q > pvc_pkg::ACC_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      cmd_new = (q > pvc_pkg::ACC_W'(32'h7FFF_FFFF)) ? 32'h8000_0000 : (~q[31:0] + 32'd1);
    end

    // Error: command minus measurement, saturated.
    err_diff = {cmd_r[31], cmd_r} - {v_r[31], v_r};
    if (err_diff[32] != err_diff[31]) begin
      err_sat = err_diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      err_sat = err_diff[31:0];
    end

    // Trapezoid sum (twice the area), saturated to 48 bits.
    int_sum = {{2{integ_r[47]}}, integ_r} + {{18{e_r[31]}}, e_r}
            + {{18{last_err_r[31]}}, last_err_r};
    if ((int_sum[49:47] != 3'b000) && (int_sum[49:47] != 3'b111)) begin
      int_sat = int_sum[49] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    end else begin
      int_sat = int_sum[47:0];
    end

    de_diff = {e_r[31], e_r} - {last_err_r[31], last_err_r};
    de_mag  = de_diff[32] ? (~de_diff + 33'd1) : de_diff;
    ni_mag  = new_int_r[47] ? (~new_int_r + 48'd1) : new_int_r;
    sum_mag = sum_r[63] ? (~sum_r + 64'd1) : sum_r;

    sat_pos = $signed({31'd0, sat_r});
    sat_neg = -sat_pos;
  end

  // Sequencer: walks the shared unit through mix, error, three product terms and the clamp.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    decay_nxt     = decay_r;
    steady_nxt    = steady_r;
    gain_nxt      = gain_r;
    dcoef_nxt     = dcoef_r;
    icoef_nxt     = icoef_r;
    sat_nxt       = sat_r;
    cmd_nxt       = cmd_r;
    last_err_nxt  = last_err_r;
    integ_nxt     = integ_r;
    v_nxt         = v_r;
    e_nxt         = e_r;
    new_int_nxt   = new_int_r;
    opm_nxt       = opm_r;
    tneg_nxt      = tneg_r;
    sum_nxt       = sum_r;
    drv_nxt       = drv_r;
    out_drive_nxt = out_drive_r;
    out_clamp_nxt = out_clamp_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    load_out      = !out_valid_r || out_tready;

    ctl         = '0;
    mul_a       = opm_r[31:0];
    mul_b       = coef;
    in_tready   = 1'b0;

    case (op_r)
      pvc_pkg::OP_MIX: ctl.sh = SH_DECAY;
      pvc_pkg::OP_INT: ctl.sh = SH_INT;
      default:         ctl.sh = SH_FRAC;
    endcase

    case (state_r)
      pvc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          v_nxt     = in_tdata;
          op_nxt    = pvc_pkg::OP_MIX;
          state_nxt = pvc_pkg::ST_MIX0;
        end
      end
      pvc_pkg::ST_MIX0: begin
        // command * decay
        mul_a     = cmd_mag;
        mul_b     = 32'(d_eff);
        ctl.clr   = 1'b1;
        state_nxt = pvc_pkg::ST_MIX1;
      end
      pvc_pkg::ST_MIX1: begin
        // steady * (one - decay); fold in the first product with the command's sign
        mul_a       = steady_mag;
        mul_b       = 32'(d_comp);
        ctl.acc_en  = 1'b1;
        ctl.acc_neg = cmd_r[31];
        state_nxt   = pvc_pkg::ST_MIX2;
      end
      pvc_pkg::ST_MIX2: begin
        ctl.acc_en  = 1'b1;
        ctl.acc_neg = steady_r[31];
        state_nxt   = pvc_pkg::ST_NORM;
      end
      pvc_pkg::ST_LO: begin
        // low 32 bits of the operand magnitude
        mul_a     = opm_r[31:0];
        ctl.clr   = 1'b1;
        state_nxt = pvc_pkg::ST_HI;
      end
      pvc_pkg::ST_HI: begin
        mul_a      = opm_r[63:32];
        ctl.acc_en = 1'b1;
        state_nxt  = pvc_pkg::ST_HIADD;
      end
      pvc_pkg::ST_HIADD: begin
        ctl.acc_en = 1'b1;
        ctl.acc_hi = 1'b1;
        state_nxt  = pvc_pkg::ST_NORM;
      end
      pvc_pkg::ST_NORM: begin
        ctl.norm_en = 1'b1;
        // the mix sign is known only once both products are in
        if (op_r == pvc_pkg::OP_MIX) begin
          tneg_nxt = acc_sign;
        end
        state_nxt = pvc_pkg::ST_SHIFT;
      end
      pvc_pkg::ST_SHIFT: begin
        case (op_r)
          pvc_pkg::OP_MIX: begin
            cmd_nxt   = cmd_new;
            state_nxt = pvc_pkg::ST_ERR;
          end
          pvc_pkg::OP_DER: begin
            sum_nxt   = {{32{e_r[31]}}, e_r} + {{2{term[61]}}, term};
            opm_nxt   = 64'(ni_mag);
            tneg_nxt  = new_int_r[47];
            op_nxt    = pvc_pkg::OP_INT;
            state_nxt = pvc_pkg::ST_LO;
          end
          pvc_pkg::OP_INT: begin
            sum_nxt   = sum_r + {{2{term[61]}}, term};
            state_nxt = pvc_pkg::ST_GLOAD;
          end
          default: begin
            drv_nxt   = term;
            state_nxt = pvc_pkg::ST_CLAMP;
          end
        endcase
      end
      pvc_pkg::ST_ERR: begin
        e_nxt     = err_sat;
        state_nxt = pvc_pkg::ST_INTG;
      end
      pvc_pkg::ST_INTG: begin
        new_int_nxt = int_sat;
        opm_nxt     = 64'(de_mag);
        tneg_nxt    = de_diff[32];
        op_nxt      = pvc_pkg::OP_DER;
        state_nxt   = pvc_pkg::ST_LO;
      end
      pvc_pkg::ST_GLOAD: begin
        opm_nxt   = sum_mag;
        tneg_nxt  = sum_r[63];
        op_nxt    = pvc_pkg::OP_GAIN;
        state_nxt = pvc_pkg::ST_LO;
      end
      pvc_pkg::ST_CLAMP: begin
        // hold until the output register frees up
        if (load_out) begin
          out_valid_nxt = 1'b1;
          if (drv_r > sat_pos) begin
            out_drive_nxt = sat_pos[31:0];
            out_clamp_nxt = pvc_pkg::CLAMP_HIGH;
          end else if (drv_r < sat_neg) begin
            out_drive_nxt = sat_neg[31:0];
            out_clamp_nxt = pvc_pkg::CLAMP_LOW;
          end else begin
            // no clamp: commit this step's integral increment
            out_drive_nxt = drv_r[31:0];
            out_clamp_nxt = pvc_pkg::CLAMP_NONE;
            integ_nxt     = new_int_r;
          end
          last_err_nxt = e_r;
          state_nxt    = pvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pvc_pkg::ST_IDLE;
      end
    endcase

    // Writes must arrive only while idle (the block does not enforce it); drop unknown indexes.
    if (cfg_wr_en) begin
      case (pvc_pkg::pvc_reg_t'(cfg_addr))
        pvc_pkg::REG_DECAY:  decay_nxt  = cfg_wdata[16:0];
        pvc_pkg::REG_STEADY: steady_nxt = cfg_wdata;
        pvc_pkg::REG_INIT:   cmd_nxt    = cfg_wdata;
        pvc_pkg::REG_GAIN:   gain_nxt   = cfg_wdata;
        pvc_pkg::REG_DCOEF:  dcoef_nxt  = cfg_wdata;
        pvc_pkg::REG_ICOEF:  icoef_nxt  = cfg_wdata;
        pvc_pkg::REG_SAT:    sat_nxt    = cfg_wdata[30:0];
        default:             decay_nxt  = decay_r;
      endcase
    end
  end

  // Control, configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pvc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      decay_r     <= pvc_pkg::DECAY_ONE;
      steady_r    <= '0;
      gain_r      <= 32'(1) << FRAC_BITS;
      dcoef_r     <= '0;
      icoef_r     <= '0;
      sat_r       <= 31'h7FFF_FFFF;
      cmd_r       <= '0;
      last_err_r  <= '0;
      integ_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      decay_r     <= decay_nxt;
      steady_r    <= steady_nxt;
      gain_r      <= gain_nxt;
      dcoef_r     <= dcoef_nxt;
      icoef_r     <= icoef_nxt;
      sat_r       <= sat_nxt;
      cmd_r       <= cmd_nxt;
      last_err_r  <= last_err_nxt;
      integ_r     <= integ_nxt;
    end
  end

  // Payload of the sample in flight and of the output beat
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    v_r         <= v_nxt;
    e_r         <= e_nxt;
    new_int_r   <= new_int_nxt;
    opm_r       <= opm_nxt;
    tneg_r      <= tneg_nxt;
    sum_r       <= sum_nxt;
    drv_r       <= drv_nxt;
    out_drive_r <= out_drive_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_clamp_r;

  // A beat flagged high-clamped carries exactly the saturation value.
  `PVC_ASSERT_IMP(a_clamp_high_value, clk, rst_n, out_tvalid && out_tuser == pvc_pkg::CLAMP_HIGH, out_tdata == {1'b0, sat_r})
  // An unclamped beat lies inside the saturation band.
  `PVC_ASSERT_IMP(a_unclamped_in_band, clk, rst_n, out_tvalid && out_tuser == pvc_pkg::CLAMP_NONE, ($signed(out_tdata) <= $signed({1'b0, sat_r})) && ($signed(out_tdata) >= -$signed({1'b0, sat_r})))
  // One sample at a time: an accepted beat closes the input until its result is formed.
  `PVC_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // Leaving the clamp step always presents a result beat.
  `PVC_ASSERT_NXT(a_clamp_loads_out, clk, rst_n, state_r == pvc_pkg::ST_CLAMP && load_out, out_tvalid)

endmodule

// File: rtl/pvc_mac_unit.sv
// Shared multiply-accumulate unit: 32x32 multiplier, signed accumulator, rounding normalizer.
// Depends on pvc_pkg; driven by the sequencer in pid_voltage_clamp_core.
module pvc_mac_unit (
  input  logic                          clk,
  input  pvc_pkg::pvc_mac_ctl_t         ctl,
  input  logic [31:0]                   mul_a,
  input  logic [31:0]                   mul_b,
  output logic [pvc_pkg::ACC_W-1:0]     q,
  output logic                          acc_sign
);

  logic [63:0]               prod_r;
  logic [pvc_pkg::ACC_W-1:0] acc_r;
  logic [pvc_pkg::ACC_W-1:0] mag_r;
  logic [pvc_pkg::ACC_W-1:0] addend;
  logic [pvc_pkg::ACC_W-1:0] half;

  always_comb begin
    addend = pvc_pkg::ACC_W'(prod_r);
    if (ctl.acc_hi) begin
      addend = pvc_pkg::ACC_W'(prod_r) << 32;
    end
    // Subtract by adding the complement with a carry in.
    if (ctl.acc_neg) begin
      addend = ~addend;
    end
    half     = pvc_pkg::ACC_W'(1) << (ctl.sh - pvc_pkg::SH_W'(1));
    acc_sign = acc_r[pvc_pkg::ACC_W-1];
    q        = mag_r >> ctl.sh;
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + addend + pvc_pkg::ACC_W'(ctl.acc_neg);
    end
    // Magnitude plus half, in one add: |x| + h = ~x + (h + 1) for negative x.
    if (ctl.norm_en) begin
      mag_r <= (acc_sign ? ~acc_r : acc_r) + half + pvc_pkg::ACC_W'(acc_sign);
    end
  end

endmodule

// File: sim/drive_predictor_pkg.sv
`timescale 1ns / 100ps
// Predictor and scoreboard for the PID voltage clamp: mirrors the registers and the
// filter, error and integral state, and checks each drive beat against the oldest prediction.
// Depends on pvc_pkg.
package drive_predictor_pkg;
  import pvc_pkg::*;

  class drive_predictor;
    bit [16:0]   decay;
    int          steady;
    bit [31:0]   gain;
    bit [31:0]   dcoef;
    bit [31:0]   icoef;
    bit [30:0]   sat_lim;
    longint      command_v;
    longint      last_err;
    longint      err_sum;
    logic [31:0] drive_q[$];
    logic [1:0]  clamp_q[$];
    int unsigned errors;

    function new();
      decay     = DECAY_ONE;
      steady    = 0;
      gain      = 32'd1 << FRAC_BITS_DEF;
      dcoef     = '0;
      icoef     = '0;
      sat_lim   = '1;
      command_v = 0;
      last_err  = 0;
      err_sum   = 0;
      errors    = 0;
    endfunction

    function longint clip(longint v, int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // Round to nearest on the magnitude, ties away from zero.
    function longint round_half_away(longint v, int sh);
      bit        neg;
      bit [63:0] m;
      neg = v < 0;
      m = neg ? -v : v;
      m = (m + (64'd1 << (sh - 1))) >> sh;
      return neg ? -longint'(m) : longint'(m);
    endfunction

    // (a * b) >> sh with rounding, magnitude capped at the term limit.
    function longint scaled_product(longint a, bit [31:0] b, int sh);
      bit         neg;
      bit [63:0]  m;
      bit [127:0] p;
      neg = a < 0;
      m = neg ? -a : a;
      p = {64'd0, m} * {96'd0, b};
      p = (p + (128'd1 << (sh - 1))) >> sh;
      if (p > TERM_LIMIT) p = TERM_LIMIT;
      return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function void note_write(logic [2:0] idx, logic [31:0] data);
      case (pvc_reg_t'(idx))
        REG_DECAY:  decay = data[16:0];
        REG_STEADY: steady = int'(data);
        REG_INIT:   command_v = longint'(int'(data));
        REG_GAIN:   gain = data;
        REG_DCOEF:  dcoef = data;
        REG_ICOEF:  icoef = data;
        REG_SAT:    sat_lim = data[30:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [31:0] v);
      longint     meas;
      longint     d;
      longint     mix;
      longint     e;
      longint     grown;
      longint     total;
      longint     drv;
      longint     lim;
      logic [1:0] cl;
      meas = longint'(int'(v));
      // A decay above one acts as one.
      d = (decay > DECAY_ONE) ? longint'(DECAY_ONE) : longint'(decay);
      mix = command_v * d + longint'(steady) * (longint'(DECAY_ONE) - d);
      command_v = clip(round_half_away(mix, DECAY_BITS), 32);
      e = clip(command_v - meas, 32);
      grown = clip(err_sum + e + last_err, 48);
      total = e + scaled_product(e - last_err, dcoef, FRAC_BITS_DEF)
                + scaled_product(grown, icoef, FRAC_BITS_DEF + 1);
      drv = scaled_product(total, gain, FRAC_BITS_DEF);
      lim = longint'(sat_lim);
      if (drv > lim) begin
        drv = lim;
        cl = CLAMP_HIGH;
      end else if (drv < -lim) begin
        drv = -lim;
        cl = CLAMP_LOW;
      end else begin
        err_sum = grown;
        cl = CLAMP_NONE;
      end
      last_err = e;
      drive_q.push_back(drv[31:0]);
      clamp_q.push_back(cl);
    endfunction

    function int outstanding();
      return drive_q.size();
    endfunction

    function void check_result(logic [31:0] drv, logic [1:0] cl);
      logic [31:0] want_drv;
      logic [1:0]  want_cl;
      if (drive_q.size() == 0) begin
        errors++;
        if (errors <= 100)
          $error("drive beat with no sample pending: drive_current %h clamp_state %0d", drv, cl);
        return;
      end
      want_drv = drive_q.pop_front();
      want_cl = clamp_q.pop_front();
      // Keep the log short once a design is clearly broken; the count still grows.
      if (drv !== want_drv) begin
        errors++;
        if (errors <= 100) $error("drive_current: expected %h, actual %h", want_drv, drv);
      end
      if (cl !== want_cl) begin
        errors++;
        if (errors <= 100) $error("clamp_state: expected %0d, actual %0d", want_cl, cl);
      end
    endfunction
  endclass

endpackage

// File: sim/pid_voltage_clamp_core_test.sv
`timescale 1ns / 100ps
// Self-checking bench for pid_voltage_clamp_core: directed corner samples, randomized
// controller settings with stalls on both sides, and a short soak that grows the integral.
// Depends on pvc_pkg, drive_predictor_pkg and the RTL of the block.
module pid_voltage_clamp_core_test;
  import pvc_pkg::*;
  import drive_predictor_pkg::*;

  // Index 7 is not a register; the block must ignore writes to it.
  localparam logic [2:0]  REG_UNUSED    = 3'd7;
  localparam logic [31:0] V_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] V_MIN         = 32'h8000_0000;
  localparam logic [31:0] ONE_Q16       = 32'h0001_0000;
  localparam int          RANDOM_PHASES = 12;
  localparam int          PHASE_BEATS   = 104;
  // Each soak beat adds almost 2^32 to the integral.
  localparam int          SOAK_BEATS    = 40;
  localparam int          QUIET_RESULTS = 1265;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          TAIL_CYCLES   = 40;
  localparam int          STALL_LIMIT   = 3000;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [31:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [2:0]  cfg_addr   = '0;
  logic [31:0] cfg_wdata  = '0;
  logic        in_tready;
  logic        out_tvalid;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  drive_predictor drive_model = new();
  bit             sender_idles = 1'b1;
  int unsigned    drives_seen  = 0;
  int unsigned    quiet_cycles = 0;

  always #5 clk = ~clk;

  pid_voltage_clamp_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [31:0] measured_voltage
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] drive_current
    .out_tuser  (out_tuser),   // [1:0] clamp_state
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Offer one sample beat and hold it until the block takes it. Keep tvalid high into
  // the next beat unless a gap is drawn, so tvalid never gets two updates in one step.
  task automatic send_sample(input logic [31:0] v);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    drive_model.note_sample(v);
    if (sender_idles && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // Drop tvalid and wait until every predicted drive beat has come back; the block is
  // idle then, since every sample yields exactly one result.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (drive_model.outstanding() != 0) @(posedge clk);
  endtask

  // Leave cfg_wr_en high between back-to-back writes; the caller lowers it after the batch.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    drive_model.note_write(idx, val);
  endtask

  task automatic write_all(input logic [31:0] decay, input logic [31:0] steady,
                           input logic [31:0] init, input logic [31:0] gain,
                           input logic [31:0] dcoef, input logic [31:0] icoef,
                           input logic [31:0] sat);
    write_reg(REG_DECAY, decay);
    write_reg(REG_STEADY, steady);
    write_reg(REG_INIT, init);
    write_reg(REG_GAIN, gain);
    write_reg(REG_DCOEF, dcoef);
    write_reg(REG_ICOEF, icoef);
    write_reg(REG_SAT, sat);
    cfg_wr_en <= 1'b0;
  endtask

  // Styles: 0 raw 32 bit noise (upper bits masked by the block), 5 extremes only,
  // anything else a controller that mostly tracks without clamping.
  function automatic logic [31:0] pick_reg_value(pvc_reg_t r, int style);
    bit hi_end;
    hi_end = $urandom_range(0, 1);
    if (style == 0) return $urandom();
    if (style == 5) begin
      case (r)
        REG_DECAY:              return hi_end ? 32'h0001_0000 : 32'd0;
        REG_STEADY, REG_INIT:   return hi_end ? V_MAX : V_MIN;
        REG_SAT:                return hi_end ? V_MAX : 32'd0;
        default:                return hi_end ? 32'hFFFF_FFFF : 32'd0;
      endcase
    end
    case (r)
      REG_DECAY:            return $urandom_range(55000, 65536);
      REG_STEADY, REG_INIT: return $urandom_range(0, 400 << 16) - (200 << 16);
      REG_GAIN:             return $urandom_range(0, 4 << 16);
      REG_DCOEF:            return $urandom_range(0, 3 << 16);
      REG_ICOEF:            return $urandom_range(0, 1 << 14);
      REG_SAT:              return hi_end ? V_MAX : $urandom_range(16 << 16, 4000 << 16);
      default:              return $urandom();
    endcase
  endfunction

  // Mostly track the command with a small, variable error so the integral and derivative
  // paths do real work; the rest is wide noise and the range ends.
  function automatic logic [31:0] pick_voltage();
    longint      v;
    int unsigned dice;
    int unsigned span;
    dice = $urandom_range(0, 99);
    span = 1 << $urandom_range(4, 22);
    if (dice < 60)
      v = drive_model.command_v + longint'($urandom_range(0, 2 * span)) - longint'(span);
    else if (dice < 80)
      v = longint'(int'($urandom())) >>> $urandom_range(8, 12);
    else if (dice < 95)
      v = longint'(int'($urandom()));
    else begin
      case ($urandom_range(0, 3))
        0:       v = longint'(int'(V_MIN));
        1:       v = longint'(int'(V_MAX));
        2:       v = 0;
        default: v = -1;
      endcase
    end
    if (v > longint'(int'(V_MAX))) v = longint'(int'(V_MAX));
    if (v < longint'(int'(V_MIN))) v = longint'(int'(V_MIN));
    return v[31:0];
  endfunction

  // Stimulus: reset, directed corners, randomized phases, integral soak.
  initial begin
    int style;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: unity gain, no filter motion, so the drive is just minus the sample.
    // The minimum sample drives the error past the 32 bit range.
    send_sample(32'd0);
    send_sample(V_MAX);
    send_sample(V_MIN);
    send_sample(32'd1);
    send_sample(32'hFFFF_FFFF);

    // Every register at a limit, decay above one through the unmasked bits, plus a
    // write to the unused index: huge products saturate, and the drive clamps both ways.
    settle();
    write_all(32'hFFFF_FFFF, V_MAX, V_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    cfg_wr_en <= 1'b0;
    send_sample(V_MAX);
    send_sample(V_MIN);
    send_sample(32'd0);
    send_sample(V_MIN);
    send_sample(V_MAX);

    // Command snaps to 1.0, limit 8.0: zero error, small error, then a clamp high and a
    // clamp low that must both leave the integral alone.
    settle();
    write_all(32'd0, ONE_Q16, 32'd0, ONE_Q16, ONE_Q16, 32'h0000_8000, 32'h0008_0000);
    send_sample(ONE_Q16);
    send_sample(32'h0003_0000);
    send_sample(32'hFFF0_0000);
    send_sample(32'h0010_0000);
    send_sample(ONE_Q16);

    // Zero gain against a zero limit: a zero drive is not a clamp.
    settle();
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_SAT, 32'd0);
    write_reg(REG_UNUSED, 32'h5A5A_A5A5);
    cfg_wr_en <= 1'b0;
    send_sample(V_MAX);
    send_sample(V_MIN);

    // Random phases: rewrite a random subset of registers, then stream samples.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      style = $urandom_range(0, 5);
      settle();
      for (int k = 0; k < 7; k++)
        if ($urandom_range(0, (k == REG_INIT) ? 2 : 1) == 0)
          write_reg(3'(k), pick_reg_value(pvc_reg_t'(k), style));
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, $urandom());
      cfg_wr_en <= 1'b0;
      sender_idles = ($urandom_range(0, 2) != 0);
      repeat (PHASE_BEATS) send_sample(pick_voltage());
    end

    // Soak with zero gain and the error pinned at its maximum so the integral grows
    // large; no gaps from here on.
    settle();
    write_all(32'd0, V_MAX, 32'd0, 32'd0, 32'd0, 32'd0, V_MAX);
    sender_idles = 1'b0;
    repeat (SOAK_BEATS) send_sample(V_MIN);

    // Turn gain and integral on to read the grown integral back through the drive.
    settle();
    write_reg(REG_GAIN, ONE_Q16);
    write_reg(REG_ICOEF, 32'd1);
    cfg_wr_en <= 1'b0;
    send_sample(V_MIN);
    send_sample(V_MIN);
    send_sample(V_MAX);
    send_sample(V_MAX);

    // Drain, then leave room for any stray beat to show up.
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (drive_model.errors == 0)
      $display("pid_voltage_clamp_core_test passed");
    else
      $display("pid_voltage_clamp_core_test failed");
    $finish;
  end

  // Result side: check each accepted beat, stall in short bursts, and twice hold off for a
  // long stretch so the block backs up and stalls its input. Stop stalling near the end.
  initial begin : drive_sink
    int unsigned stall;
    int unsigned hold;
    stall = 0;
    hold  = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        drive_model.check_result(out_tdata, out_tuser);
        drives_seen++;
        if (drives_seen == 400 || drives_seen == 900) hold = HOLD_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_tready <= 1'b0;
      end else if (drives_seen < QUIET_RESULTS && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: count cycles with no beat and no register write on any port.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("pid_voltage_clamp_core_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/pvc_pkg.sv
rtl/pvc_mac_unit.sv
rtl/pid_voltage_clamp_core.sv
sim/drive_predictor_pkg.sv
sim/pid_voltage_clamp_core_test.sv
